@@ rtl/core/gbn_link_pkg.sv @@
// Package: shared types, codes and sequence helpers for the go-back-N link controller.
package gbn_link_pkg;

  localparam int unsigned MAX_SEQ   = 7;
  localparam int unsigned SEQ_W     = 3;
  localparam int unsigned SEQ_DEPTH = MAX_SEQ + 1;
  localparam int unsigned PAY_W     = 32;

  typedef logic [SEQ_W-1:0] seq_t;
  typedef logic [PAY_W-1:0] pay_t;

  typedef enum logic [1:0] {
    OP_PACKET   = 2'd0,
    OP_FRAME    = 2'd1,
    OP_CKSUM    = 2'd2,
    OP_TIMEOUT  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ACT_SEND    = 2'd0,
    ACT_DELIVER = 2'd1,
    ACT_STOP    = 2'd2,
    ACT_STATUS  = 2'd3
  } act_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEND,
    ST_DELIVER,
    ST_ACK,
    ST_RESEND,
    ST_STATUS
  } state_t;

  localparam seq_t SEQ_MAX = seq_t'(MAX_SEQ);

  // lo <= x < hi, circularly
  function automatic logic in_window(seq_t lo, seq_t x, seq_t hi);
    in_window = ((lo <= x) && (x < hi)) || ((hi < lo) && (lo <= x)) ||
                ((x < hi) && (hi < lo));
  endfunction

endpackage

@@ rtl/core/go_back_n_link_controller.sv @@
// Top level: go-back-N link sender/receiver with the window buffer in a synchronous RAM.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid/in_ready, operation, payload,    | input
//           | in_seq, in_ack                            |
//   out     | out_valid/out_ready, action, seq, ack,    | output
//           | payload, net_enable, refused, last        |
//
// One event at a time: after accept the sequencer takes one step per result item
// (send, deliver, stop, status). On a frame arrival the ack scan ends with a
// check that finds no further timer to stop; a frame that is delivered and
// stops seven timers is the longest event. While out_ready allows, resent
// frames stream one per cycle from the window RAM read port, read one frame ahead.
// rst_n (synchronous) clears the sequence counters and control; the window RAM
// is not cleared. A stalled out_ready holds the sequencer in its current step.
module go_back_n_link_controller
  import gbn_link_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       in_operation,
  input  logic [PAY_W-1:0] in_payload,
  input  logic [SEQ_W-1:0] in_seq,
  input  logic [SEQ_W-1:0] in_ack,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       out_action,
  output logic [SEQ_W-1:0] out_seq,
  output logic [SEQ_W-1:0] out_ack,
  output logic [PAY_W-1:0] out_payload,
  output logic             out_net_enable,
  output logic             out_refused,
  output logic             out_last
);

  // link state
  state_t state_r, state_nxt;
  seq_t   send_next_r, send_next_nxt;
  seq_t   oldest_r, oldest_nxt;
  seq_t   expected_r, expected_nxt;
  seq_t   count_r, count_nxt;
  seq_t   left_r, left_nxt;         // frames still to resend

  // latched event
  pay_t   pay_r;
  seq_t   ack_r;
  logic   refused_r, refused_nxt;

  // window RAM
  pay_t   win_mem [SEQ_DEPTH];
  pay_t   rd_data_r;
  seq_t   rd_addr;
  logic   wr_en;

  // output register
  logic   out_valid_r;
  act_t   out_action_r;
  seq_t   out_seq_r, out_ack_r;
  pay_t   out_payload_r;
  logic   out_en_r, out_ref_r, out_last_r;

  // result being produced this cycle
  logic   emit;
  act_t   e_action;
  seq_t   e_seq, e_ack;
  pay_t   e_pay;
  logic   e_en, e_ref, e_last;

  logic   slot_free;
  logic   accept;
  seq_t   piggy_ack;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign piggy_ack = expected_r + SEQ_MAX;   // expected - 1 mod 8
  assign wr_en     = accept && (op_t'(in_operation) == OP_PACKET) && (count_r < SEQ_MAX);

  always_comb begin
    state_nxt     = state_r;
    send_next_nxt = send_next_r;
    oldest_nxt    = oldest_r;
    expected_nxt  = expected_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    refused_nxt   = refused_r;
    rd_addr       = send_next_r;
    emit          = 1'b0;
    e_action      = ACT_STATUS;
    e_seq         = '0;
    e_ack         = '0;
    e_pay         = '0;
    e_en          = 1'b0;
    e_ref         = 1'b0;
    e_last        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          refused_nxt = 1'b0;
          unique case (op_t'(in_operation))
            OP_PACKET: begin
              if (count_r < SEQ_MAX) begin
                state_nxt = ST_SEND;
              end else begin
                refused_nxt = 1'b1;
                state_nxt   = ST_STATUS;
              end
            end
            OP_FRAME: begin
              state_nxt = (in_seq == expected_r) ? ST_DELIVER : ST_ACK;
            end
            OP_CKSUM: begin
              state_nxt = ST_STATUS;
            end
            OP_TIMEOUT: begin
              // rewind and prefetch the oldest frame
              send_next_nxt = oldest_r;
              rd_addr       = oldest_r;
              left_nxt      = count_r;
              state_nxt     = (count_r != '0) ? ST_RESEND : ST_STATUS;
            end
            default: state_nxt = ST_STATUS;
          endcase
        end
      end
      ST_SEND: begin
        if (slot_free) begin
          emit          = 1'b1;
          e_action      = ACT_SEND;
          e_seq         = send_next_r;
          e_ack         = piggy_ack;
          e_pay         = pay_r;
          count_nxt     = count_r + seq_t'(1);
          send_next_nxt = send_next_r + seq_t'(1);
          state_nxt     = ST_STATUS;
        end
      end
      ST_DELIVER: begin
        if (slot_free) begin
          emit         = 1'b1;
          e_action     = ACT_DELIVER;
          e_pay        = pay_r;
          expected_nxt = expected_r + seq_t'(1);
          state_nxt    = ST_ACK;
        end
      end
      ST_ACK: begin
        // cumulative ack: stop one timer per cycle while the output slot is free
        if ((count_r != '0) && in_window(oldest_r, ack_r, send_next_r)) begin
          if (slot_free) begin
            emit       = 1'b1;
            e_action   = ACT_STOP;
            e_seq      = oldest_r;
            oldest_nxt = oldest_r + seq_t'(1);
            count_nxt  = count_r - seq_t'(1);
          end
        end else begin
          state_nxt = ST_STATUS;
        end
      end
      ST_RESEND: begin
        // rd_data_r always holds window[send_next_r] here
        if (slot_free) begin
          emit          = 1'b1;
          e_action      = ACT_SEND;
          e_seq         = send_next_r;
          e_ack         = piggy_ack;
          e_pay         = rd_data_r;
          send_next_nxt = send_next_r + seq_t'(1);
          rd_addr       = send_next_r + seq_t'(1);
          left_nxt      = left_r - seq_t'(1);
          if (left_r == seq_t'(1)) begin
            state_nxt = ST_STATUS;
          end
        end
      end
      ST_STATUS: begin
        if (slot_free) begin
          emit      = 1'b1;
          e_action  = ACT_STATUS;
          e_en      = (count_r < SEQ_MAX);
          e_ref     = refused_r;
          e_last    = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      send_next_r <= '0;
      oldest_r    <= '0;
      expected_r  <= '0;
      count_r     <= '0;
      left_r      <= '0;
      refused_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      send_next_r <= send_next_nxt;
      oldest_r    <= oldest_nxt;
      expected_r  <= expected_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      refused_r   <= refused_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // event latch and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pay_r <= in_payload;
      ack_r <= in_ack;
    end
    if (emit) begin
      out_action_r  <= e_action;
      out_seq_r     <= e_seq;
      out_ack_r     <= e_ack;
      out_payload_r <= e_pay;
      out_en_r      <= e_en;
      out_ref_r     <= e_ref;
      out_last_r    <= e_last;
    end
  end

  // window RAM: one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[send_next_r] <= in_payload;
    end
    rd_data_r <= win_mem[rd_addr];
  end

  assign out_valid      = out_valid_r;
  assign out_action     = out_action_r;
  assign out_seq        = out_seq_r;
  assign out_ack        = out_ack_r;
  assign out_payload    = out_payload_r;
  assign out_net_enable = out_en_r;
  assign out_refused    = out_ref_r;
  assign out_last       = out_last_r;

`ifndef SYNTHESIS
  // window never holds more than MAX_SEQ frames
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SEQ_MAX)
    else $error("outstanding count above window size");

  // between events the send pointer sits count frames past the oldest
  a_window_span: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (send_next_r == seq_t'(oldest_r + count_r)))
    else $error("send pointer out of step with window");

  // only the status item carries last
  a_last_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_action == ACT_STATUS))
    else $error("last set on a non-status item");

  // one event at a time
  a_one_event: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken again before status item");
`endif

endmodule
